[rtl/rtc_twe_pkg.sv]
// Shared constants and helper functions for the clock burst-write encoder.
`default_nettype none

package rtc_twe_pkg;

  // Field widths used inside the pipeline.
  localparam int unsigned YearW = 14;
  localparam int unsigned YyW   = 15;
  localparam int unsigned SumW  = 15;

  // Reciprocal for a divide by 100, exact for dividends below 43699.
  localparam logic [12:0] Div100Mul   = 13'd5243;
  localparam int unsigned Div100Shift = 19;
  localparam logic [6:0]  Hundred     = 7'd100;

  // Calendar constants.
  localparam logic [8:0] YearOffset = 9'd400;
  localparam logic [3:0] MonthFirst = 4'd1;
  localparam logic [3:0] MonthLast  = 4'd12;
  localparam logic [3:0] MonthMarch = 4'd3;

  // Fixed byte codes.
  localparam logic [7:0] ControlByte = 8'h80;
  localparam logic [2:0] NoWeekday   = 3'd0;
  localparam logic [2:0] Sunday      = 3'd1;

  // Sakamoto month offsets, indexed by the month number 1..12.
  function automatic logic [2:0] month_offset(input logic [3:0] month);
    logic [2:0] off;
    case (month)
      4'd1:    off = 3'd0;
      4'd2:    off = 3'd3;
      4'd3:    off = 3'd2;
      4'd4:    off = 3'd5;
      4'd5:    off = 3'd0;
      4'd6:    off = 3'd3;
      4'd7:    off = 3'd5;
      4'd8:    off = 3'd1;
      4'd9:    off = 3'd4;
      4'd10:   off = 3'd6;
      4'd11:   off = 3'd2;
      4'd12:   off = 3'd4;
      default: off = 3'd0;
    endcase
    return off;
  endfunction

  // Packed BCD of a value below 100; tens come from a multiply by 103/1024.
  function automatic logic [7:0] to_bcd(input logic [6:0] v);
    logic [16:0] prod;
    logic [3:0]  tens;
    logic [6:0]  units;
    prod  = 17'(v) * 17'd103;
    tens  = prod[13:10];
    units = v - (7'(tens) * 7'd10);
    return {tens, units[3:0]};
  endfunction

  // Remainder modulo 7 by folding 3-bit groups, since 8 is 1 modulo 7.
  function automatic logic [2:0] mod7(input logic [SumW-1:0] s);
    logic [5:0] a;
    logic [3:0] b;
    logic [3:0] c;
    a = 6'(s[2:0]) + 6'(s[5:3]) + 6'(s[8:6]) + 6'(s[11:9]) + 6'(s[14:12]);
    b = 4'(a[2:0]) + 4'(a[5:3]);
    c = 4'(b[2:0]) + 4'(b[3]);
    if (c >= 4'd7) begin
      c = c - 4'd7;
    end
    return c[2:0];
  endfunction

endpackage

`default_nettype wire

[rtl/rtc_time_encode_with_weekday.sv]
// Three-stage pipeline that packs a date and time into clock burst-write bytes.
// Throughput is one request per cycle while the output side does not stall; each
// stage holds one request and the stall from the output side reaches the input
// through per-stage ready terms, so bubbles fill.
// The stage-one divide by 100, the stage-two weekday sum and the stage-three
// modulo-7 fold set the stage depths. Reset clears all valid bits at once.
`default_nettype none

module rtc_time_encode_with_weekday (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_stall_o,
  input  wire logic [13:0] year_full_i,
  input  wire logic [3:0]  month_num_i,
  input  wire logic [4:0]  day_num_i,
  input  wire logic [4:0]  hour_num_i,
  input  wire logic [5:0]  minute_num_i,
  input  wire logic [5:0]  second_num_i,
  output logic             out_valid_o,
  input  wire logic        out_stall_i,
  output logic [6:0]       seconds_byte_o,
  output logic [6:0]       minutes_byte_o,
  output logic [5:0]       hours_byte_o,
  output logic [5:0]       date_byte_o,
  output logic [4:0]       month_byte_o,
  output logic [2:0]       weekday_byte_o,
  output logic [7:0]       year_byte_o,
  output logic [7:0]       control_byte_o,
  output logic             month_ok_o
);

  // Bytes that are final after the first stage.
  typedef struct packed {
    logic [6:0] seconds;
    logic [6:0] minutes;
    logic [5:0] hours;
    logic [5:0] date;
    logic [4:0] month;
    logic       ok;
  } time_bytes_t;

  typedef struct packed {
    time_bytes_t                       tb;
    logic [rtc_twe_pkg::YearW-1:0]     year;
    logic [7:0]                        year_div;
    logic [rtc_twe_pkg::YyW-1:0]       yy;
    logic [7:0]                        yy_div;
    logic [2:0]                        off;
    logic [4:0]                        day;
  } stage1_t;

  typedef struct packed {
    time_bytes_t                  tb;
    logic [7:0]                   year_byte;
    logic [rtc_twe_pkg::SumW-1:0] sum;
  } stage2_t;

  typedef struct packed {
    time_bytes_t tb;
    logic [7:0]  year_byte;
    logic [2:0]  weekday;
  } stage3_t;

  logic    v1_q, v2_q, v3_q;
  logic    rdy1, rdy2, rdy3;
  stage1_t s1_d, s1_q;
  stage2_t s2_d, s2_q;
  stage3_t s3_d, s3_q;

  // Each stage moves when it is empty or the next one moves.
  assign rdy3       = !v3_q || !out_stall_i;
  assign rdy2       = !v2_q || rdy3;
  assign rdy1       = !v1_q || rdy2;
  assign in_stall_o = !rdy1;

  // Stage one: BCD of the time fields, shifted year and both divides by 100.
  logic                          jan_feb;
  logic [rtc_twe_pkg::YyW-1:0]   yy;
  logic [26:0]                   year_prod;
  logic [27:0]                   yy_prod;
  logic [7:0]                    bcd_sec, bcd_min, bcd_hour, bcd_day, bcd_mon;

  always_comb begin
    jan_feb   = month_num_i < rtc_twe_pkg::MonthMarch;
    yy        = rtc_twe_pkg::YyW'(year_full_i) + rtc_twe_pkg::YyW'(rtc_twe_pkg::YearOffset)
              - rtc_twe_pkg::YyW'(jan_feb);
    year_prod = 27'(year_full_i) * 27'(rtc_twe_pkg::Div100Mul);
    yy_prod   = 28'(yy) * 28'(rtc_twe_pkg::Div100Mul);
    bcd_sec   = rtc_twe_pkg::to_bcd(7'(second_num_i));
    bcd_min   = rtc_twe_pkg::to_bcd(7'(minute_num_i));
    bcd_hour  = rtc_twe_pkg::to_bcd(7'(hour_num_i));
    bcd_day   = rtc_twe_pkg::to_bcd(7'(day_num_i));
    bcd_mon   = rtc_twe_pkg::to_bcd(7'(month_num_i));

    s1_d.tb.seconds = bcd_sec[6:0];
    s1_d.tb.minutes = bcd_min[6:0];
    s1_d.tb.hours   = bcd_hour[5:0];
    s1_d.tb.date    = bcd_day[5:0];
    s1_d.tb.month   = bcd_mon[4:0];
    s1_d.tb.ok      = (month_num_i >= rtc_twe_pkg::MonthFirst)
                   && (month_num_i <= rtc_twe_pkg::MonthLast);
    s1_d.year       = year_full_i;
    s1_d.year_div   = year_prod[rtc_twe_pkg::Div100Shift +: 8];
    s1_d.yy         = yy;
    s1_d.yy_div     = yy_prod[rtc_twe_pkg::Div100Shift +: 8];
    s1_d.off        = rtc_twe_pkg::month_offset(month_num_i);
    s1_d.day        = day_num_i;
  end

  // Stage two: year remainder to BCD and the Sakamoto weekday sum.
  logic [rtc_twe_pkg::YearW-1:0] year_rem;

  always_comb begin
    year_rem = s1_q.year
             - (rtc_twe_pkg::YearW'(s1_q.year_div) * rtc_twe_pkg::YearW'(rtc_twe_pkg::Hundred));
    s2_d.tb        = s1_q.tb;
    s2_d.year_byte = rtc_twe_pkg::to_bcd(year_rem[6:0]);
    s2_d.sum       = s1_q.yy
                   + (s1_q.yy >> 2)
                   - rtc_twe_pkg::SumW'(s1_q.yy_div)
                   + rtc_twe_pkg::SumW'(s1_q.yy_div[7:2])
                   + rtc_twe_pkg::SumW'(s1_q.off)
                   + rtc_twe_pkg::SumW'(s1_q.day);
  end

  // Stage three: fold the sum modulo 7 and code the weekday.
  always_comb begin
    s3_d.tb        = s2_q.tb;
    s3_d.year_byte = s2_q.year_byte;
    if (s2_q.tb.ok) begin
      s3_d.weekday = rtc_twe_pkg::mod7(s2_q.sum) + rtc_twe_pkg::Sunday;
    end else begin
      s3_d.weekday = rtc_twe_pkg::NoWeekday;
    end
  end

  // Valid bits travel with the stage registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else begin
      if (rdy1) begin
        v1_q <= in_valid_i;
      end
      if (rdy2) begin
        v2_q <= v1_q;
      end
      if (rdy3) begin
        v3_q <= v2_q;
      end
    end
  end

  // Payload registers load only when their stage moves.
  always_ff @(posedge clk_i) begin
    if (rdy1 && in_valid_i) begin
      s1_q <= s1_d;
    end
    if (rdy2 && v1_q) begin
      s2_q <= s2_d;
    end
    if (rdy3 && v2_q) begin
      s3_q <= s3_d;
    end
  end

  // Result ports.
  assign out_valid_o    = v3_q;
  assign seconds_byte_o = s3_q.tb.seconds;
  assign minutes_byte_o = s3_q.tb.minutes;
  assign hours_byte_o   = s3_q.tb.hours;
  assign date_byte_o    = s3_q.tb.date;
  assign month_byte_o   = s3_q.tb.month;
  assign weekday_byte_o = s3_q.weekday;
  assign year_byte_o    = s3_q.year_byte;
  assign control_byte_o = rtc_twe_pkg::ControlByte;
  assign month_ok_o     = s3_q.tb.ok;

endmodule

`default_nettype wire

[rtl/rtc_twe_chk.sv]
// Port-level checker for the clock burst-write encoder, bound to the top level.
`default_nettype none

module rtc_twe_chk (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        in_valid_i,
  input wire logic        in_stall_o,
  input wire logic        out_valid_o,
  input wire logic        out_stall_i,
  input wire logic [4:0]  month_byte_o,
  input wire logic [2:0]  weekday_byte_o,
  input wire logic [7:0]  control_byte_o,
  input wire logic        month_ok_o
);

  // A stalled result stays offered.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("result dropped while stalled");

  // With the output side free, every stage moves, so an offered request is taken.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !out_stall_i |-> !in_stall_o)
    else $error("request stalled while the output side is free");

  // The control byte always enables write protect.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> control_byte_o == rtc_twe_pkg::ControlByte)
    else $error("control byte is not write protect");

  // A weekday is present exactly when the month is good.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (month_ok_o == (weekday_byte_o != rtc_twe_pkg::NoWeekday)))
    else $error("weekday and month flag disagree");

  // The month flag matches the BCD month byte of the same request.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (month_ok_o == ((month_byte_o != 5'h00) && (month_byte_o <= 5'h12))))
    else $error("month flag does not match month byte");

endmodule

bind rtc_time_encode_with_weekday rtc_twe_chk u_rtc_twe_chk (.*);

`default_nettype wire
